/* hw/rtl/skjp_pkg.sv */
`timescale 1ns / 1ps

package skjp_pkg;

  // Default size limits of the line buffers and the row counter
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 4096;

  // Field and register widths
  localparam int PixelW       = 8;
  localparam int ImageWidthW  = 11;
  localparam int ImageHeightW = 13;
  localparam int CfgIndexW    = 1;
  localparam int CfgDataW     = 13;

  // Register values after reset, before clamping
  localparam int ResetWidth  = 640;
  localparam int ResetHeight = 480;

  // Smallest legal image side
  localparam int MinSide = 3;

  // Skeleton pixel value and the neighbour count that keeps it
  localparam logic [PixelW-1:0] White = 8'd255;
  localparam int MinNeighbours = 3;

  typedef enum logic [CfgIndexW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_index_e;

  // One accepted pixel on its way from the counters to the window
  typedef struct packed {
    logic [PixelW-1:0] pixel;    // pixel value, zero for drains
    logic              clear;    // empty the window before the shift
    logic              interior; // window centre lies off the image border
    logic              emit;     // this transaction produces a result
    logic              last;     // result is the final pixel of the image
  } item_t;

endpackage

/* hw/rtl/skjp_window.sv */
`timescale 1ns / 1ps

module skjp_window #(
  parameter int MAX_WIDTH = skjp_pkg::DefMaxWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr_i,
  input  skjp_pkg::item_t                     item_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr_i,
  input  logic                                adv_i,
  output logic [skjp_pkg::PixelW-1:0]         pixel_o
);
  import skjp_pkg::*;

  localparam int LineW = PixelW + 1;

  // Line buffer entry: flag of the row two above, pixel of the row above
  logic [LineW-1:0] line_mem [MAX_WIDTH];
  logic [LineW-1:0] rd_q;
  logic             rd_older;
  logic [PixelW-1:0] rd_prev;

  // Window columns of "is white" flags, bit r is row r; column 0 is the left one
  logic [2:0][2:0]   win_q, win_base, win_n;
  logic [PixelW-1:0] mid_q, mid_base;
  logic [2:0]        new_col;
  logic [7:0]        nbrs;
  logic [3:0]        count;

  assign rd_older = rd_q[LineW-1];
  assign rd_prev  = rd_q[PixelW-1:0];

  // Read ahead at acceptance, write back when the transaction leaves the window
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      line_mem[wr_addr_i] <= {(rd_prev == White), item_i.pixel};
    end
    if (rd_en_i) begin
      rd_q <= line_mem[rd_addr_i];
    end
  end

  // Shift the window and load the new column
  always_comb begin
    win_base = item_i.clear ? '0 : win_q;
    mid_base = item_i.clear ? '0 : mid_q;
    new_col  = {(item_i.pixel == White), (rd_prev == White), rd_older};
    win_n    = {new_col, win_base[2], win_base[1]};
  end

  // Count the white neighbours of the centre
  always_comb begin
    nbrs  = {win_n[0], win_n[2], win_n[1][2], win_n[1][0]};
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + 4'(nbrs[i]);
    end
  end

  // Drop weak interior skeleton pixels
  always_comb begin
    pixel_o = mid_base;
    if (item_i.interior && (mid_base == White) && (count < 4'(MinNeighbours))) begin
      pixel_o = '0;
    end
  end

  // Hold the window, empty it after the final pixel of an image
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      mid_q <= '0;
    end else if (adv_i) begin
      if (item_i.last) begin
        win_q <= '0;
        mid_q <= '0;
      end else begin
        win_q <= win_n;
        mid_q <= rd_prev;
      end
    end
  end

endmodule

/* hw/rtl/skeleton_junction_prune_3x3.sv */
`timescale 1ns / 1ps

// Channel  | Direction | Signals
// ---------+-----------+---------------------------------------------------
// cfg      | in        | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i
// in       | in        | in_valid_i, in_ready_o, in_pixel_i, drain_i
// out      | out       | out_valid_o, out_ready_i, out_pixel_o, last_pixel_o
//
// One input transaction per cycle while in_ready_o is high; a result passes the window
// stage and then the output register; the stream runs image_width + 1 transactions behind.
// The line buffer is one memory port pair, read at acceptance, written back on adv.
// Reset clears counters, window and registers; the line buffer is not cleared.
// A stalled output holds the window stage, which in turn holds in_ready_o low.

module skeleton_junction_prune_3x3 #(
  parameter int MAX_WIDTH  = skjp_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = skjp_pkg::DefMaxHeight
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [skjp_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [skjp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [skjp_pkg::PixelW-1:0]      in_pixel_i,
  input  logic                             drain_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [skjp_pkg::PixelW-1:0]      out_pixel_o,
  output logic                             last_pixel_o
);
  import skjp_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int CmpW  = ColW + 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RowW  = $clog2(MAX_HEIGHT + 2);
  localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WCmpW = (WW > ImageWidthW) ? WW : ImageWidthW;
  localparam int HCmpW = (HW > ImageHeightW) ? HW : ImageHeightW;
  localparam int RstW  = (ResetWidth < MinSide) ? MinSide :
                         ((ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth);
  localparam int RstH  = (ResetHeight < MinSide) ? MinSide :
                         ((ResetHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetHeight);
  localparam int RstTotal = RstW * RstH;

  // Configuration, kept clamped
  logic [WW-1:0]    w_q, w_d, w_clamp;
  logic [HW-1:0]    h_q, h_d, h_clamp;
  logic [TW-1:0]    total_q, total_d;
  logic [WCmpW-1:0] cfg_w_ext;
  logic [HCmpW-1:0] cfg_h_ext;

  // Input counters
  logic [ColW-1:0] col_q, col_d, col_base, col_cur;
  logic [RowW-1:0] row_q, row_d, row_base, row_cur;
  logic [TW-1:0]   oc_q, oc_d, oc_base, oc_inc;
  logic [CmpW-1:0] col_inc;
  logic            restart_pre, wrap, col_end, row_past, in_acc;
  item_t           item;

  // Window stage and output register
  logic            s1_valid_q;
  item_t           s1_item_q;
  logic [ColW-1:0] s1_col_q;
  logic            adv;
  logic [PixelW-1:0] win_pixel;
  logic            out_valid_q;
  logic [PixelW-1:0] out_pixel_q;
  logic            out_last_q;

  assign cfg_ready_o = 1'b1;

  // Clamp the written register value to the legal side lengths
  always_comb begin
    cfg_w_ext = WCmpW'(cfg_data_i[ImageWidthW-1:0]);
    cfg_h_ext = HCmpW'(cfg_data_i[ImageHeightW-1:0]);
    if (cfg_w_ext < WCmpW'(MinSide)) begin
      w_clamp = WW'(MinSide);
    end else if (cfg_w_ext > WCmpW'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = cfg_w_ext[WW-1:0];
    end
    if (cfg_h_ext < HCmpW'(MinSide)) begin
      h_clamp = HW'(MinSide);
    end else if (cfg_h_ext > HCmpW'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = cfg_h_ext[HW-1:0];
    end
  end

  // Decode the register write and refresh the pixel total
  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgImageWidth:  w_d = w_clamp;
        CfgImageHeight: h_d = h_clamp;
        default: ;
      endcase
    end
    total_d = TW'(w_d) * TW'(h_d);
  end

  assign in_acc = in_valid_i && in_ready_o;

  // Position the arriving pixel and advance the counters
  always_comb begin
    restart_pre = (oc_q >= total_q);
    col_base    = restart_pre ? '0 : col_q;
    row_base    = restart_pre ? '0 : row_q;
    oc_base     = restart_pre ? '0 : oc_q;

    wrap    = (CmpW'(col_base) >= CmpW'(w_q));
    col_cur = wrap ? '0 : col_base;
    row_cur = wrap ? row_base + RowW'(1) : row_base;

    row_past      = (row_cur >= RowW'(h_q));
    item.pixel    = (drain_i || row_past) ? '0 : in_pixel_i;
    item.clear    = restart_pre;
    item.emit     = (row_cur >= RowW'(2)) || ((row_cur == RowW'(1)) && (col_cur != '0));
    item.interior = (col_cur >= ColW'(2)) && (row_cur >= RowW'(2)) && (row_cur < RowW'(h_q));
    oc_inc        = oc_base + TW'(1);
    item.last     = item.emit && (oc_inc == total_q);

    col_inc = CmpW'(col_cur) + CmpW'(1);
    col_end = (col_inc >= CmpW'(w_q));
    col_d   = col_end ? '0 : col_inc[ColW-1:0];
    row_d   = col_end ? row_cur + RowW'(1) : row_cur;
    oc_d    = item.emit ? oc_inc : oc_base;
    if (item.last) begin
      col_d = '0;
      row_d = '0;
      oc_d  = '0;
    end
  end

  // Advance the window stage when its result has somewhere to go
  assign adv        = s1_valid_q && (!s1_item_q.emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= WW'(RstW);
      h_q         <= HW'(RstH);
      total_q     <= TW'(RstTotal);
      col_q       <= '0;
      row_q       <= '0;
      oc_q        <= '0;
      s1_valid_q  <= 1'b0;
      s1_item_q   <= '0;
      s1_col_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_pixel_q <= '0;
    end else begin
      w_q     <= w_d;
      h_q     <= h_d;
      total_q <= total_d;

      // Take the transaction into the window stage
      if (in_acc) begin
        col_q      <= col_d;
        row_q      <= row_d;
        oc_q       <= oc_d;
        s1_valid_q <= 1'b1;
        s1_item_q  <= item;
        s1_col_q   <= col_cur;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end

      // Load or drop the output register
      if (adv && s1_item_q.emit) begin
        out_valid_q <= 1'b1;
        out_pixel_q <= win_pixel;
        out_last_q  <= s1_item_q.last;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  skjp_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_cur),
    .item_i    (s1_item_q),
    .wr_addr_i (s1_col_q),
    .adv_i     (adv),
    .pixel_o   (win_pixel)
  );

  assign out_valid_o  = out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign last_pixel_o = out_last_q;

endmodule
